>>> hw/rtl/gcr_pkg.sv
`default_nettype none

package gcr_pkg;

    // Field widths of one epoch and one result.
    localparam int unsigned VEL_W    = 24;
    localparam int unsigned ANGLE_W  = 16;

    // Rotator sizing: velocities scaled by 2^16 plus CORDIC gain and sign headroom.
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned XY_W     = VEL_W + FRAC_W + 4;
    // Angle accumulator: pi is 2^31, with room for the quarter-turn start plus the arctan sum.
    localparam int unsigned Z_W      = 34;

    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned CORDIC_ITERS =
        (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int unsigned ITER_W   = $clog2(ATAN_ENTRIES);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1073741824);
    localparam logic signed [Z_W-1:0] ROUND_HALF   = Z_W'(64'sd32768);

    // Heading limits for the rotation pre-turn, in input angle units.
    localparam logic signed [ANGLE_W-1:0] HEAD_POS_LIMIT = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] HEAD_NEG_LIMIT = -16'sd16384;

    localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

    // Arctangent of 2^-i in units where pi is 2^31.
    function automatic logic [31:0] atan_lookup(input logic [ITER_W-1:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gcr_if.sv
`default_nettype none

// Epoch channel into the block.
interface gcr_in_if;
    import gcr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [VEL_W-1:0]   vel_east;
    logic signed [VEL_W-1:0]   vel_north;
    logic signed [ANGLE_W-1:0] antenna_heading;
    logic                      fix_updated;

    modport source (output valid, vel_east, vel_north, antenna_heading, fix_updated,
                    input ready);
    modport sink   (input valid, vel_east, vel_north, antenna_heading, fix_updated,
                    output ready);
endinterface

// Result channel out of the block.
interface gcr_out_if;
    import gcr_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] course;
    logic                      reversing;

    modport source (output valid, course, reversing, input ready);
    modport sink   (input valid, course, reversing, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gnss_course_with_reverse_detect.sv
`default_nettype none

// GNSS course with reverse detection. One beat in carries an epoch (east and north
// velocity in mm/s, dual-antenna heading as a 16-bit binary angle, fix flag); one beat
// out carries the course and a reversing flag. On a fresh fix the course is
// atan2(north, east) from a CORDIC vectoring pass and is held; otherwise the held course
// is used. A CORDIC rotation pass by the antenna heading gives the sign of
// sin(heading)*east + cos(heading)*north; when negative the course is turned by half a
// revolution. Both passes share one shift-add rotator run by a small microprogram, one
// CORDIC step per cycle. An epoch with a fix runs the vectoring pass and stores the course
// before the rotation pass; one without a fix runs only the rotation pass. A new epoch
// is accepted only once the previous one has reached the output register; that register
// holds a result while the next epoch is computed.
module gnss_course_with_reverse_detect
    import gcr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    gcr_in_if.sink     in_ch,
    gcr_out_if.source  out_ch
);

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_LOAD_VEC,
        OP_ITER_VEC,
        OP_STORE,
        OP_LOAD_ROT,
        OP_ITER_ROT,
        OP_EMIT
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_NO_VALID,
        JC_NO_FIX,
        JC_MORE_ITERS,
        JC_OUT_BUSY
    } jcond_t;

    localparam int unsigned PC_W = 3;

    typedef struct packed {
        op_t             op;
        jcond_t          cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // Program step addresses.
    localparam logic [PC_W-1:0] PC_WAIT     = 3'd0;
    localparam logic [PC_W-1:0] PC_LOAD_VEC = 3'd1;
    localparam logic [PC_W-1:0] PC_ITER_VEC = 3'd2;
    localparam logic [PC_W-1:0] PC_STORE    = 3'd3;
    localparam logic [PC_W-1:0] PC_LOAD_ROT = 3'd4;
    localparam logic [PC_W-1:0] PC_ITER_ROT = 3'd5;
    localparam logic [PC_W-1:0] PC_EMIT     = 3'd6;
    localparam logic [PC_W-1:0] PC_RETURN   = 3'd7;

    // Microprogram read-only store.
    function automatic uword_t ucode(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            PC_WAIT:     w = '{OP_CAPTURE,  JC_NO_VALID,   PC_WAIT};
            PC_LOAD_VEC: w = '{OP_LOAD_VEC, JC_NO_FIX,     PC_LOAD_ROT};
            PC_ITER_VEC: w = '{OP_ITER_VEC, JC_MORE_ITERS, PC_ITER_VEC};
            PC_STORE:    w = '{OP_STORE,    JC_NONE,       PC_WAIT};
            PC_LOAD_ROT: w = '{OP_LOAD_ROT, JC_NONE,       PC_WAIT};
            PC_ITER_ROT: w = '{OP_ITER_ROT, JC_MORE_ITERS, PC_ITER_ROT};
            PC_EMIT:     w = '{OP_EMIT,     JC_OUT_BUSY,   PC_EMIT};
            PC_RETURN:   w = '{OP_NOP,      JC_ALWAYS,     PC_WAIT};
            default:     w = '{OP_NOP,      JC_ALWAYS,     PC_WAIT};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0]           pc_reg, pc_next;
    logic [ITER_W-1:0]         iter_reg;
    logic signed [VEL_W-1:0]   east_reg, north_reg;
    logic signed [ANGLE_W-1:0] head_reg;
    logic                      fix_reg;
    logic signed [XY_W-1:0]    x_reg, y_reg;
    logic signed [Z_W-1:0]     z_reg;
    logic [ANGLE_W-1:0]        held_reg;
    logic                      out_valid_reg;
    logic [ANGLE_W-1:0]        out_course_reg;
    logic                      out_rev_reg;

    uword_t                    uw;
    logic                      taken;
    logic                      out_busy;
    logic signed [XY_W-1:0]    east_ext, north_ext, dx, dy;
    logic signed [Z_W-1:0]     atan_z, head_ext, z_round;
    logic                      rev;

    assign uw       = ucode(pc_reg);
    assign out_busy = out_valid_reg && !out_ch.ready;

    // Branch decision for the current step.
    always_comb
    begin
        case (uw.cond)
            JC_NONE:       taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NO_VALID:   taken = !in_ch.valid;
            JC_NO_FIX:     taken = !fix_reg;
            JC_MORE_ITERS: taken = (iter_reg != ITER_LAST);
            JC_OUT_BUSY:   taken = out_busy;
            default:       taken = 1'b1;
        endcase
        pc_next = taken ? uw.target : pc_reg + 1'b1;
    end

    // Shared rotator operands.
    assign east_ext  = {{(XY_W - VEL_W - FRAC_W){east_reg[VEL_W-1]}}, east_reg, FRAC_W'(0)};
    assign north_ext = {{(XY_W - VEL_W - FRAC_W){north_reg[VEL_W-1]}}, north_reg, FRAC_W'(0)};
    assign head_ext  = {{(Z_W - ANGLE_W - FRAC_W){head_reg[ANGLE_W-1]}}, head_reg, FRAC_W'(0)};
    assign dx        = y_reg >>> iter_reg;
    assign dy        = x_reg >>> iter_reg;
    assign atan_z    = Z_W'(atan_lookup(iter_reg));
    assign z_round   = z_reg + ROUND_HALF;
    assign rev       = y_reg[XY_W-1];

    // Program counter, held course and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (uw.op == OP_STORE)
            begin
                if (east_reg == '0 && north_reg == '0)
                begin
                    held_reg <= '0;
                end
                else
                begin
                    held_reg <= z_round[FRAC_W +: ANGLE_W];
                end
            end
            if (uw.op == OP_EMIT && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (uw.op)
            OP_CAPTURE:
            begin
                if (in_ch.valid)
                begin
                    east_reg  <= in_ch.vel_east;
                    north_reg <= in_ch.vel_north;
                    head_reg  <= in_ch.antenna_heading;
                    fix_reg   <= in_ch.fix_updated;
                end
            end
            OP_LOAD_VEC:
            begin
                iter_reg <= '0;
                if (!east_reg[VEL_W-1])
                begin
                    x_reg <= east_ext;
                    y_reg <= north_ext;
                    z_reg <= '0;
                end
                else if (!north_reg[VEL_W-1])
                begin
                    x_reg <= north_ext;
                    y_reg <= -east_ext;
                    z_reg <= QUARTER_TURN;
                end
                else
                begin
                    x_reg <= -north_ext;
                    y_reg <= east_ext;
                    z_reg <= -QUARTER_TURN;
                end
            end
            OP_ITER_VEC:
            begin
                iter_reg <= iter_reg + 1'b1;
                if (!y_reg[XY_W-1] && y_reg != '0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_z;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_z;
                end
            end
            OP_LOAD_ROT:
            begin
                iter_reg <= '0;
                if (head_reg > HEAD_POS_LIMIT)
                begin
                    x_reg <= -north_ext;
                    y_reg <= east_ext;
                    z_reg <= head_ext - QUARTER_TURN;
                end
                else if (head_reg < HEAD_NEG_LIMIT)
                begin
                    x_reg <= north_ext;
                    y_reg <= -east_ext;
                    z_reg <= head_ext + QUARTER_TURN;
                end
                else
                begin
                    x_reg <= east_ext;
                    y_reg <= north_ext;
                    z_reg <= head_ext;
                end
            end
            OP_ITER_ROT:
            begin
                iter_reg <= iter_reg + 1'b1;
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_z;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_z;
                end
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_course_reg <= rev ? held_reg + HALF_TURN : held_reg;
                    out_rev_reg    <= rev;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready      = (pc_reg == PC_WAIT);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.course    = out_course_reg;
    assign out_ch.reversing = out_rev_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gcr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned DRAIN_WAIT  = 2 * CORDIC_ITERS + 30;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic signed [VEL_W-1:0]   VEL_MAX  = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0]   VEL_MIN  = 24'sh800000;
    localparam logic signed [ANGLE_W-1:0] HEAD_MAX = 16'sh7FFF;
    localparam logic signed [ANGLE_W-1:0] HEAD_MIN = 16'sh8000;

    localparam longint QUARTER_UNITS = 64'sd1073741824;
    localparam longint VEL_SCALE     = 64'sd65536;

    // Arctangent of 2^-i, in units where pi is 2^31.
    localparam longint ARCTAN_UNITS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic [ANGLE_W-1:0] course;
        logic               reversing;
    } course_result_t;

    logic clk;
    logic rst_n;

    gcr_in_if  in_ch ();
    gcr_out_if out_ch ();

    gnss_course_with_reverse_detect i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state and the queue of courses still to come out.
    logic [ANGLE_W-1:0] held_course;
    course_result_t     pending_courses[$];
    course_result_t     oldest_course;

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          stall_requests;
    int          stall_served;
    int          hold_left;
    int          mismatch_count;
    int unsigned cycle_count;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_courses.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Course of the velocity vector by a CORDIC vectoring pass.
    function automatic logic [ANGLE_W-1:0] course_from_velocity(longint east, longint north);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = east * VEL_SCALE;
        y = north * VEL_SCALE;
        z = 0;
        if (east == 0 && north == 0)
            return '0;
        // Pre-turn by a quarter revolution into the right half-plane.
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = QUARTER_UNITS;
            end
            else
            begin
                t = x; x = -y; y = t; z = -QUARTER_UNITS;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + ARCTAN_UNITS[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - ARCTAN_UNITS[i];
            end
        end
        return ANGLE_W'((z + 64'sd32768) >>> 16);
    endfunction

    // Sign of the velocity projected on the antenna heading, by a rotation pass.
    function automatic logic heading_opposes_velocity(longint east, longint north,
                                                      longint heading);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = east * VEL_SCALE;
        y = north * VEL_SCALE;
        z = heading * VEL_SCALE;
        if (z > QUARTER_UNITS)
        begin
            t = x; x = -y; y = t; z = z - QUARTER_UNITS;
        end
        else if (z < -QUARTER_UNITS)
        begin
            t = x; x = y; y = -t; z = z + QUARTER_UNITS;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ARCTAN_UNITS[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ARCTAN_UNITS[i];
            end
        end
        return (y < 0);
    endfunction

    // Work out the result of one accepted epoch and queue it.
    task automatic predict_course(input logic signed [VEL_W-1:0] east,
                                  input logic signed [VEL_W-1:0] north,
                                  input logic signed [ANGLE_W-1:0] heading,
                                  input logic fix);
        course_result_t res;
        if (fix)
            held_course = course_from_velocity(longint'(east), longint'(north));
        res.reversing = heading_opposes_velocity(longint'(east), longint'(north),
                                                 longint'(heading));
        res.course = res.reversing ? held_course + HALF_TURN : held_course;
        pending_courses.push_back(res);
    endtask

    // Offer one epoch, after a random gap, and wait until the beat is taken.
    task automatic send_epoch(input logic signed [VEL_W-1:0] east,
                              input logic signed [VEL_W-1:0] north,
                              input logic signed [ANGLE_W-1:0] heading,
                              input logic fix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.vel_east        <= east;
        in_ch.vel_north       <= north;
        in_ch.antenna_heading <= heading;
        in_ch.fix_updated     <= fix;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_course(east, north, heading, fix);
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_requests != stall_served)
            begin
                stall_served = stall_served + 1;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_courses.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: course %0d reversing %0b",
                             out_ch.course, out_ch.reversing);
            end
            else
            begin
                oldest_course = pending_courses.pop_front();
                if (out_ch.course !== oldest_course.course ||
                    out_ch.reversing !== oldest_course.reversing)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: course exp %0d got %0d, reversing exp %0b got %0b",
                                 $signed(oldest_course.course), out_ch.course,
                                 oldest_course.reversing, out_ch.reversing);
                end
            end
        end
    end

    function automatic logic signed [VEL_W-1:0] random_velocity();
        case ($urandom_range(9))
            0:       return '0;
            1:       return VEL_MAX;
            2:       return VEL_MIN;
            3, 4, 5: return VEL_W'($signed($urandom_range(4000)) - 2000);
            6:       return VEL_W'($signed($urandom_range(200000)) - 100000);
            default: return VEL_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ANGLE_W-1:0] random_heading();
        case ($urandom_range(7))
            0:       return HEAD_MAX;
            1:       return HEAD_MIN;
            2:       return HEAD_POS_LIMIT + ANGLE_W'($signed($urandom_range(4)) - 2);
            3:       return HEAD_NEG_LIMIT + ANGLE_W'($signed($urandom_range(4)) - 2);
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    // Extremes of each field, the zero vector, a course of exactly pi, and the
    // heading right at and just past the quarter-turn limits.
    task automatic test_directed_cases();
        send_epoch('0, '0, '0, 1'b1);
        send_epoch(-24'sd1000, '0, '0, 1'b1);
        send_epoch(VEL_MIN, '0, 16'sd100, 1'b1);
        send_epoch(VEL_MAX, VEL_MAX, HEAD_MAX, 1'b1);
        send_epoch(VEL_MIN, VEL_MIN, HEAD_MIN, 1'b1);
        send_epoch(VEL_MAX, VEL_MIN, HEAD_POS_LIMIT, 1'b1);
        send_epoch(VEL_MIN, VEL_MAX, HEAD_NEG_LIMIT, 1'b1);
        send_epoch(24'sd1, -24'sd1, HEAD_POS_LIMIT + 16'sd1, 1'b1);
        send_epoch(-24'sd1, 24'sd1, HEAD_NEG_LIMIT - 16'sd1, 1'b1);
        send_epoch('0, VEL_MAX, '0, 1'b1);
        send_epoch('0, VEL_MIN, '0, 1'b1);
        send_epoch(VEL_MAX, '0, HEAD_MIN, 1'b1);
        send_epoch(-24'sd3000, 24'sd4000, HEAD_MAX, 1'b1);
        send_epoch(24'sd2500, 24'sd2500, 16'sh6000, 1'b1);
    endtask

    // Epochs without a fresh fix keep the stored course, turned or not.
    task automatic test_held_course();
        send_epoch(24'sd500, -24'sd700, 16'sd100, 1'b0);
        send_epoch(-24'sd500, 24'sd700, -16'sd20000, 1'b0);
        send_epoch('0, '0, 16'sd12345, 1'b0);
        send_epoch(VEL_MIN, VEL_MAX, HEAD_MIN, 1'b0);
        send_epoch(VEL_MAX, VEL_MIN, HEAD_MAX, 1'b0);
        send_epoch(-24'sd1200, -24'sd900, '0, 1'b1);
        send_epoch(24'sd1200, 24'sd900, '0, 1'b0);
    endtask

    // The receiver stops for a long stretch while epochs keep coming.
    task automatic test_output_stall();
        int saved_tx;
        saved_tx       = tx_idle_pct;
        tx_idle_pct    = 0;
        stall_requests = stall_requests + 1;
        repeat (6)
            send_epoch(random_velocity(), random_velocity(), random_heading(),
                       ($urandom_range(3) != 0));
        tx_idle_pct = saved_tx;
    endtask

    // Random epochs, mostly with a fresh fix; some with one axis at zero.
    task automatic test_random_epochs(input int count);
        logic signed [VEL_W-1:0] east;
        logic signed [VEL_W-1:0] north;
        repeat (count)
        begin
            east  = random_velocity();
            north = random_velocity();
            case ($urandom_range(9))
                0:       east  = '0;
                1:       north = '0;
                default: ;
            endcase
            send_epoch(east, north, random_heading(), ($urandom_range(3) != 0));
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.vel_east        = '0;
        in_ch.vel_north       = '0;
        in_ch.antenna_heading = '0;
        in_ch.fix_updated     = 1'b0;
        held_course           = '0;
        tx_idle_pct           = 12;
        rx_idle_pct           = 52;
        stall_requests        = 0;
        stall_served          = 0;
        hold_left             = 0;
        mismatch_count        = 0;
        cycle_count           = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_held_course();
        test_output_stall();
        test_random_epochs(130);

        tx_idle_pct = 52;
        rx_idle_pct = 12;
        test_random_epochs(135);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_epochs(135);
        in_ch.valid <= 1'b0;

        // Drain, then give any stray beat time to show up.
        while (pending_courses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_courses.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
